// File: hdl/eegdf_pkg.sv
package eegdf_pkg;

    localparam int FRAME_BYTES = 33;
    localparam int CHANNELS    = 8;

    localparam int POS_W = 6;
    localparam int CH_W  = 3;

    localparam logic [7:0] HEADER_BYTE = 8'hA0;

    // first position after the last sample group
    localparam logic [POS_W-1:0] SAMPLE_END  = POS_W'(2 + 3 * CHANNELS);
    localparam logic [POS_W-1:0] POS_HEADER  = POS_W'(0);
    localparam logic [POS_W-1:0] POS_COUNTER = POS_W'(1);
    localparam logic [POS_W-1:0] POS_LAST    = POS_W'(FRAME_BYTES - 1);
    localparam logic [CH_W-1:0]  LAST_CH     = CH_W'(CHANNELS - 1);

    // byte phase inside one 3-byte sample group
    localparam logic [1:0] PH_HIGH = 2'd0;
    localparam logic [1:0] PH_MID  = 2'd1;
    localparam logic [1:0] PH_LOW  = 2'd2;

    typedef struct packed {
        logic [CH_W-1:0]    chan_id;
        logic signed [23:0] sample_value;
        logic [7:0]         sample_number;
        logic               header_bad;
        logic               sample_lost;
        logic               last_of_frame;
    } result_t;

endpackage

// File: hdl/eeg_packet_deframer_24bit_unit.sv
// channel   dir  signals                     contents
// s_*       in   tvalid tready tdata[7:0]    rx_byte
// m_*       out  tvalid tready tdata[39:0]   chan_id, sample_value, sample_number
//                tuser[1:0] tlast            header_bad, sample_lost / last_of_frame
// cfg_*     in   wr_en wr_data[7:0]          counter_wrap
//
// One byte per cycle unless a byte that completes a sample waits on a stalled output; a byte
// passes the input register and the framing logic, and its result then goes to the result register.
// Reset expects a header byte, counter_wrap = 255, no previous counter.
// A stalled output holds only bytes that complete a sample; other bytes keep flowing.
module eeg_packet_deframer_24bit_unit
    import eegdf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [2:0] chan_id, [26:3] sample_value,
                                   // [34:27] sample_number, [39:35] zero
    output logic [1:0]  m_tuser,   // [0] header_bad, [1] sample_lost
    output logic        m_tlast    // last_of_frame
);

    logic       advance;
    logic       byte_valid;
    logic [7:0] byte_data;
    logic       out_free;
    logic       res_load;
    result_t    res;

    eegdf_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .advance    (advance),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    eegdf_parser u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .byte_valid  (byte_valid),
        .byte_data   (byte_data),
        .out_free    (out_free),
        .advance     (advance),
        .res_load    (res_load),
        .res         (res)
    );

    eegdf_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_load (res_load),
        .res      (res),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// File: hdl/eegdf_in_stage.sv
module eegdf_in_stage
    import eegdf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       advance,
    output logic       byte_valid,
    output logic [7:0] byte_data
);

    logic       valid_reg, valid_next;
    logic [7:0] data_reg, data_next;

    assign s_tready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (s_tready)
        begin
            valid_next = s_tvalid;
            if (s_tvalid)
            begin
                data_next = s_tdata;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

endmodule

// File: hdl/eegdf_parser.sv
module eegdf_parser
    import eegdf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       byte_valid,
    input  logic [7:0] byte_data,
    input  logic       out_free,
    output logic       advance,
    output logic       res_load,
    output result_t    res
);

    logic [7:0]      wrap_reg, wrap_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [1:0]      phase_reg, phase_next;
    logic [15:0]     asm_reg, asm_next;
    logic [CH_W-1:0] ch_reg, ch_next;
    logic [7:0]      cnt_reg, cnt_next;
    logic            have_prev_reg, have_prev_next;
    logic            hdr_err_reg, hdr_err_next;
    logic            lost_reg, lost_next;

    logic       in_samples;
    logic       emits;
    logic [7:0] expect_cnt;

    assign in_samples = (pos_reg > POS_COUNTER) && (pos_reg < SAMPLE_END);
    assign emits      = in_samples && (phase_reg == PH_LOW);
    assign advance    = byte_valid && (!emits || out_free);
    assign res_load   = advance && emits;
    assign expect_cnt = (cnt_reg == wrap_reg) ? 8'd0 : cnt_reg + 8'd1;

    assign res.chan_id       = ch_reg;
    assign res.sample_value  = {asm_reg, byte_data};
    assign res.sample_number = cnt_reg;
    assign res.header_bad    = hdr_err_reg;
    assign res.sample_lost   = lost_reg;
    assign res.last_of_frame = (ch_reg == LAST_CH);

    always_comb
    begin
        wrap_next      = cfg_wr_en ? cfg_wr_data : wrap_reg;
        pos_next       = pos_reg;
        phase_next     = phase_reg;
        asm_next       = asm_reg;
        ch_next        = ch_reg;
        cnt_next       = cnt_reg;
        have_prev_next = have_prev_reg;
        hdr_err_next   = hdr_err_reg;
        lost_next      = lost_reg;
        if (advance)
        begin
            pos_next = (pos_reg == POS_LAST) ? POS_HEADER : pos_reg + POS_W'(1);
            if (pos_reg == POS_HEADER)
            begin
                hdr_err_next = (byte_data != HEADER_BYTE);
                ch_next      = '0;
                phase_next   = PH_HIGH;
            end
            else if (pos_reg == POS_COUNTER)
            begin
                lost_next      = have_prev_reg && (byte_data != expect_cnt);
                cnt_next       = byte_data;
                have_prev_next = 1'b1;
                ch_next        = '0;
                phase_next     = PH_HIGH;
            end
            else if (in_samples)
            begin
                asm_next = {asm_reg[7:0], byte_data};
                if (phase_reg == PH_LOW)
                begin
                    phase_next = PH_HIGH;
                    ch_next    = ch_reg + CH_W'(1);
                end
                else
                begin
                    phase_next = phase_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_reg      <= 8'hFF;
            pos_reg       <= POS_HEADER;
            phase_reg     <= PH_HIGH;
            ch_reg        <= '0;
            cnt_reg       <= '0;
            have_prev_reg <= 1'b0;
            hdr_err_reg   <= 1'b0;
            lost_reg      <= 1'b0;
        end
        else
        begin
            wrap_reg      <= wrap_next;
            pos_reg       <= pos_next;
            phase_reg     <= phase_next;
            ch_reg        <= ch_next;
            cnt_reg       <= cnt_next;
            have_prev_reg <= have_prev_next;
            hdr_err_reg   <= hdr_err_next;
            lost_reg      <= lost_next;
        end
    end

    // only the two older bytes of a group are kept
    always_ff @(posedge clk)
    begin
        asm_reg <= asm_next;
    end

endmodule

// File: hdl/eegdf_out_reg.sv
module eegdf_out_reg
    import eegdf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        res_load,
    input  result_t     res,
    output logic        out_free,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);

    logic    valid_reg, valid_next;
    result_t res_reg, res_next;

    assign out_free = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        res_next   = res_reg;
        if (res_load)
        begin
            valid_next = 1'b1;
            res_next   = res;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {5'd0, res_reg.sample_number, res_reg.sample_value,
                       res_reg.chan_id};
    assign m_tuser  = {res_reg.sample_lost, res_reg.header_bad};
    assign m_tlast  = res_reg.last_of_frame;

endmodule

// File: sim/tb_eeg_packet_deframer_24bit_unit.sv
`timescale 1ns / 100ps

module tb_eeg_packet_deframer_24bit_unit;
    import eegdf_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [7:0]  cfg_wr_data = 8'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    eeg_packet_deframer_24bit_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    // deframer state as seen from the byte stream
    int         frame_pos;
    logic [23:0] word_acc;
    logic [2:0]  chan_ctr;
    logic [7:0]  cur_count;
    logic [7:0]  prev_count;
    logic        seen_count;
    logic        hdr_bad_q;
    logic        lost_q;
    logic [7:0]  wrap_reg;

    result_t pending_samples[$];
    int      fail_count;
    bit      src_idle;
    bit      snk_idle;
    int      hold_len;

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("Verification failed");
        $finish;
    end

    task automatic deframe_byte(input logic [7:0] b);
        result_t r;
        logic [7:0] want;
        if (frame_pos == 0)
        begin
            hdr_bad_q = (b != HEADER_BYTE);
            word_acc  = '0;
            chan_ctr  = '0;
        end
        else if (frame_pos == 1)
        begin
            want       = (prev_count == wrap_reg) ? 8'd0 : prev_count + 8'd1;
            lost_q     = seen_count && (b != want);
            cur_count  = b;
            prev_count = b;
            seen_count = 1'b1;
            word_acc   = '0;
            chan_ctr   = '0;
        end
        else if (frame_pos < 2 + 3 * CHANNELS)
        begin
            word_acc = {word_acc[15:0], b};
            if ((frame_pos - 2) % 3 == 2)
            begin
                r.chan_id       = chan_ctr;
                r.sample_value  = word_acc;
                r.sample_number = cur_count;
                r.header_bad    = hdr_bad_q;
                r.sample_lost   = lost_q;
                r.last_of_frame = (chan_ctr == LAST_CH);
                pending_samples = {pending_samples, r};
                chan_ctr = chan_ctr + 3'd1;
                word_acc = '0;
            end
        end
        frame_pos = (frame_pos + 1 >= FRAME_BYTES) ? 0 : frame_pos + 1;
    endtask

    task automatic note_fail(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endtask

    // one byte transfer; valid stays high afterwards for back-to-back bytes
    task automatic push_byte(input logic [7:0] b);
        int gap;
        gap = src_idle ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        deframe_byte(b);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
        // trailing bytes give no result but may still be in flight
        repeat (4) @(posedge clk);
    endtask

    task automatic write_wrap(input logic [7:0] v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        wrap_reg = v;
    endtask

    function automatic logic [23:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            2: return 24'hFFFFFF;
            3: return 24'h000000;
            default: return 24'($urandom());
        endcase
    endfunction

    function automatic logic [7:0] next_count();
        return (prev_count == wrap_reg) ? 8'd0 : prev_count + 8'd1;
    endfunction

    task automatic send_packet(input logic [7:0] hdr, input logic [7:0] cnt,
                               input logic [23:0] smp[CHANNELS]);
        push_byte(hdr);
        push_byte(cnt);
        for (int i = 0; i < CHANNELS; i++)
        begin
            push_byte(smp[i][23:16]);
            push_byte(smp[i][15:8]);
            push_byte(smp[i][7:0]);
        end
        while (frame_pos != 0)
            push_byte(8'($urandom()));
    endtask

    task automatic send_rand_packet(input logic [7:0] hdr, input logic [7:0] cnt);
        logic [23:0] smp[CHANNELS];
        for (int i = 0; i < CHANNELS; i++)
            smp[i] = rand_sample();
        send_packet(hdr, cnt, smp);
    endtask

    // sink: random stall per result, or a long hold when one is requested
    initial
    begin
        int n;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            n = (hold_len > 0) ? hold_len : (snk_idle ? $urandom_range(0, 9) : 0);
            hold_len = 0;
            if (n > 0)
            begin
                m_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.chan_id       = m_tdata[2:0];
            got.sample_value  = m_tdata[26:3];
            got.sample_number = m_tdata[34:27];
            got.header_bad    = m_tuser[0];
            got.sample_lost   = m_tuser[1];
            got.last_of_frame = m_tlast;
            if (pending_samples.size() == 0)
                note_fail($sformatf("unexpected sample transfer: ch=%0d val=%0d num=%0d",
                                    got.chan_id, got.sample_value,
                                    got.sample_number));
            else
            begin
                want = pending_samples.pop_front();
                if (got.chan_id !== want.chan_id
                    || got.sample_value !== want.sample_value
                    || got.sample_number !== want.sample_number
                    || got.header_bad !== want.header_bad
                    || got.sample_lost !== want.sample_lost
                    || got.last_of_frame !== want.last_of_frame)
                    note_fail($sformatf({"sample mismatch: exp ch=%0d val=%0d num=%0d ",
                                         "hdr=%0b lost=%0b last=%0b / got ch=%0d val=%0d ",
                                         "num=%0d hdr=%0b lost=%0b last=%0b"},
                                        want.chan_id, want.sample_value,
                                        want.sample_number, want.header_bad,
                                        want.sample_lost, want.last_of_frame,
                                        got.chan_id, got.sample_value,
                                        got.sample_number, got.header_bad,
                                        got.sample_lost, got.last_of_frame));
            end
        end
    end

    task automatic test_sample_extremes();
        logic [23:0] smp[CHANNELS];
        src_idle = 1'b0;
        snk_idle = 1'b0;
        // first packet: bad header, no previous counter so never lost
        smp = '{24'h000000, 24'h7FFFFF, 24'h800000, 24'hFFFFFF,
                24'h000001, 24'hFFFFFE, 24'h123456, 24'hA5A5A5};
        send_packet(8'h00, 8'h05, smp);
        // counter gap
        smp = '{24'h800001, 24'h7FFFFE, 24'h5A5A5A, 24'h000100,
                24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hC3C3C3};
        send_packet(HEADER_BYTE, 8'h07, smp);
        send_rand_packet(8'hFF, 8'h08);
        drain();
    endtask

    task automatic test_counter_wrap();
        src_idle = 1'b1;
        snk_idle = 1'b1;
        write_wrap(8'd3);
        send_rand_packet(HEADER_BYTE, 8'd2);
        send_rand_packet(HEADER_BYTE, 8'd3);
        send_rand_packet(HEADER_BYTE, 8'd0);   // wrap after 3
        send_rand_packet(HEADER_BYTE, 8'd4);   // lost: expected 1
        send_rand_packet(HEADER_BYTE, 8'd5);   // above wrap keeps counting
        send_rand_packet(HEADER_BYTE, 8'd0);   // lost: expected 6
        write_wrap(8'd0);
        send_rand_packet(HEADER_BYTE, 8'd0);
        send_rand_packet(HEADER_BYTE, 8'd0);
        send_rand_packet(HEADER_BYTE, 8'd1);   // lost
        write_wrap(8'd255);
        send_rand_packet(HEADER_BYTE, 8'd254);
        send_rand_packet(HEADER_BYTE, 8'd255);
        send_rand_packet(HEADER_BYTE, 8'd0);
        drain();
    endtask

    task automatic test_output_backpressure();
        src_idle = 1'b0;
        snk_idle = 1'b0;
        hold_len = 150;
        for (int i = 0; i < 4; i++)
            send_rand_packet(HEADER_BYTE, next_count());
        drain();
    endtask

    task automatic test_random_stream(input int n_bytes, input logic [7:0] wrap,
                                      input bit src_gaps, input bit snk_gaps);
        int start;
        logic [7:0] hdr;
        logic [7:0] cnt;
        write_wrap(wrap);
        src_idle = src_gaps;
        snk_idle = snk_gaps;
        start = 0;
        while (start < n_bytes)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                hdr = ($urandom_range(0, 9) == 0) ? 8'($urandom()) : HEADER_BYTE;
                cnt = ($urandom_range(0, 4) == 0) ? 8'($urandom()) : next_count();
                send_rand_packet(hdr, cnt);
            end
            else
            begin
                // broken packet: random length of noise, then realign on count
                repeat ($urandom_range(1, 40)) push_byte(8'($urandom()));
                while (frame_pos != 0)
                    push_byte(8'($urandom()));
            end
            start += FRAME_BYTES;
        end
        drain();
    endtask

    initial
    begin
        frame_pos  = 0;
        word_acc   = '0;
        chan_ctr   = '0;
        cur_count  = '0;
        prev_count = '0;
        seen_count = 1'b0;
        hdr_bad_q  = 1'b0;
        lost_q     = 1'b0;
        wrap_reg   = 8'd255;
        fail_count = 0;
        src_idle   = 1'b0;
        snk_idle   = 1'b0;
        hold_len   = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_sample_extremes();
        test_counter_wrap();
        test_output_backpressure();
        test_random_stream(160, 8'd255, 1'b1, 1'b1);
        test_random_stream(130, 8'd0, 1'b0, 1'b0);
        test_random_stream(160, 8'($urandom()), 1'b1, 1'b0);
        test_random_stream(160, 8'd7, 1'b0, 1'b1);

        drain();
        repeat (8) @(posedge clk);
        fail_count += pending_samples.size();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
